/* rtl/substring_scan_finder_top_macros.svh */
// ============================================================================
// Substring scan finder assertion macros
// Shared assertion forms for the checker of the substring scan finder.
// ============================================================================
`ifndef SUBSTRING_SCAN_FINDER_TOP_MACROS_SVH
`define SUBSTRING_SCAN_FINDER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the block clock, off during reset
`define SSF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the block clock, off during reset
`define SSF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/ssf_pkg.sv */
// ============================================================================
// Substring scan finder package
// Shared constants, register indexes and types of the substring scan finder.
// ============================================================================
package ssf_pkg;

    // Default sizing of the top level
    localparam int PATTERN_MAX_DEF   = 16;
    localparam int POSITION_BITS_DEF = 32;

    // Pattern storage in bytes, fixed by the two 64-bit pattern registers
    localparam int PATTERN_STORE = 16;

    // Field widths
    localparam int LEN_BITS   = 5;
    localparam int COUNT_BITS = 32;
    localparam int POS_BITS   = 32;
    localparam int DATA_BITS  = 64;
    localparam int INDEX_BITS = 3;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [POS_BITS-1:0]   t_pos;
    typedef logic [LEN_BITS-1:0]   t_len;

    // Configuration register indexes
    typedef enum logic [INDEX_BITS-1:0] {
        CFG_PATTERN_LENGTH = 3'd0,
        CFG_PATTERN_LOW    = 3'd1,
        CFG_PATTERN_HIGH   = 3'd2,
        CFG_SEARCH_BACK    = 3'd3,
        CFG_STOP_NEWLINE   = 3'd4,
        CFG_START_POSITION = 3'd5
    } t_cfg_index;

    // Compare controls handed to the window matcher
    typedef struct packed {
        t_len length;
        logic backward;
    } t_match_ctrl;

    // One result item
    typedef struct packed {
        logic found;
        t_pos pos;
    } t_result;

endpackage

/* rtl/ssf_window_match.sv */
// ============================================================================
// Substring scan finder window matcher
// Parallel compare of the byte window against the pattern for every length.
// ============================================================================
module ssf_window_match #(
    parameter int WIN = 16
) (
    input  logic [WIN-1:0][7:0]                       i_window,
    input  logic [ssf_pkg::PATTERN_STORE-1:0][7:0]    i_pattern,
    input  ssf_pkg::t_match_ctrl                      i_ctrl,
    input  ssf_pkg::t_count                           i_count,
    output logic                                      o_match
);
    import ssf_pkg::*;

    logic [WIN-1:0] fwd_ok;
    logic [WIN-1:0] bwd_ok;
    logic [WIN-1:0] len_sel;
    logic           enough;

    // Per-length compare: forward takes the oldest byte against pattern byte 0,
    // backward takes the newest byte against pattern byte 0
    always_comb begin
        for (int l = 1; l <= WIN; l++) begin
            fwd_ok[l-1]  = 1'b1;
            bwd_ok[l-1]  = 1'b1;
            len_sel[l-1] = (i_ctrl.length == LEN_BITS'(l));
            for (int i = 0; i < l; i++) begin
                if (i_window[l-1-i] != i_pattern[i]) begin
                    fwd_ok[l-1] = 1'b0;
                end
                if (i_window[i] != i_pattern[i]) begin
                    bwd_ok[l-1] = 1'b0;
                end
            end
        end
    end

    // Window must hold at least the pattern's length of real bytes
    assign enough  = (i_count >= COUNT_BITS'(i_ctrl.length));
    assign o_match = enough && (|(len_sel & (i_ctrl.backward ? bwd_ok : fwd_ok)));

endmodule

/* rtl/substring_scan_finder_top.sv */
// ============================================================================
// Substring scan finder
// Streaming exact search for a pattern of up to 16 bytes in a text byte stream.
// ============================================================================
// Takes one text byte in every cycle while o_in_ready is high; the window
// compare and the position arithmetic sit between the window/count registers
// and a two-entry result queue, which registers the result that a byte causes.
// o_in_ready drops only while both result slots are held by the consumer.
// Configuration writes are taken at once (o_cfg_ready is always high) and
// should be made only while no search is part-way through.
module substring_scan_finder_top #(
    parameter int PATTERN_MAX   = ssf_pkg::PATTERN_MAX_DEF,
    parameter int POSITION_BITS = ssf_pkg::POSITION_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // text byte requests
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [7:0]                         i_text_byte,
    input  logic                               i_last_byte,
    // result requests
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_found,
    output logic [ssf_pkg::POS_BITS-1:0]       o_match_position,
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ssf_pkg::INDEX_BITS-1:0]     i_cfg_index,
    input  logic [ssf_pkg::DATA_BITS-1:0]      i_cfg_data
);
    import ssf_pkg::*;

    localparam int         WIN      = (PATTERN_MAX < PATTERN_STORE) ? PATTERN_MAX
                                                                    : PATTERN_STORE;
    localparam t_len       WIN_LEN  = LEN_BITS'(WIN);
    localparam logic [POS_BITS-1:0] POS_MASK =
        POS_BITS'((65'd1 << POSITION_BITS) - 65'd1);

    // Configuration registers
    t_len        r_pattern_length;
    logic [DATA_BITS-1:0] r_pattern_low;
    logic [DATA_BITS-1:0] r_pattern_high;
    logic        r_backward;
    logic        r_stop_newline;
    t_pos        r_start;

    // Search state
    logic [WIN-1:0][7:0] r_window, n_window, sh_window;
    t_count      r_bytes_read, n_bytes_read, cnt_inc;
    logic        r_answered, n_answered;

    // Result queue
    logic        r_out_valid, n_out_valid;
    logic        r_skid_valid, n_skid_valid;
    t_result     r_out_res, n_out_res;
    t_result     r_skid_res, n_skid_res;

    logic        in_accept;
    logic        pop;
    logic        push;
    logic        empty_first;
    logic        match;
    t_len        eff_len;
    t_match_ctrl match_ctrl;
    t_result     new_res;
    t_pos        raw_pos;
    logic [PATTERN_STORE-1:0][7:0] pattern;

    assign in_accept   = i_in_valid && o_in_ready;
    assign pop         = r_out_valid && i_out_ready;
    assign o_in_ready  = !r_skid_valid;
    assign o_cfg_ready = 1'b1;

    // Configuration write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length <= '0;
            r_pattern_low    <= '0;
            r_pattern_high   <= '0;
            r_backward       <= 1'b0;
            r_stop_newline   <= 1'b0;
            r_start          <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_PATTERN_LENGTH: r_pattern_length <= i_cfg_data[LEN_BITS-1:0];
                CFG_PATTERN_LOW:    r_pattern_low    <= i_cfg_data;
                CFG_PATTERN_HIGH:   r_pattern_high   <= i_cfg_data;
                CFG_SEARCH_BACK:    r_backward       <= i_cfg_data[0];
                CFG_STOP_NEWLINE:   r_stop_newline   <= i_cfg_data[0];
                CFG_START_POSITION: r_start          <= i_cfg_data[POS_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Pattern bytes and effective length, clipped to the window
    assign pattern    = {r_pattern_high, r_pattern_low};
    assign eff_len    = (r_pattern_length > WIN_LEN) ? WIN_LEN : r_pattern_length;
    assign match_ctrl = '{length: eff_len, backward: r_backward};

    // Window after taking the new byte, and saturating count
    always_comb begin
        sh_window[0] = i_text_byte;
        for (int k = 1; k < WIN; k++) begin
            sh_window[k] = r_window[k-1];
        end
    end
    assign cnt_inc = (&r_bytes_read) ? r_bytes_read : r_bytes_read + t_count'(1);

    ssf_window_match #(
        .WIN (WIN)
    ) u_window_match (
        .i_window  (sh_window),
        .i_pattern (pattern),
        .i_ctrl    (match_ctrl),
        .i_count   (cnt_inc),
        .o_match   (match)
    );

    assign empty_first = (eff_len == '0) && (r_bytes_read == '0);

    // Per-byte search step
    always_comb begin
        n_window     = r_window;
        n_bytes_read = r_bytes_read;
        n_answered   = r_answered;
        push         = 1'b0;
        new_res.found = 1'b0;
        raw_pos      = r_start;
        if (in_accept) begin
            if (r_answered) begin
                // draining to the end of the text
                if (i_last_byte) begin
                    n_answered   = 1'b0;
                    n_bytes_read = '0;
                end
            end else begin
                if (empty_first) begin
                    push          = 1'b1;
                    new_res.found = 1'b1;
                end else begin
                    n_window     = sh_window;
                    n_bytes_read = cnt_inc;
                    if (match) begin
                        push          = 1'b1;
                        new_res.found = 1'b1;
                        raw_pos       = r_backward ? (r_start - cnt_inc)
                                        : (r_start + cnt_inc - t_count'(eff_len));
                    end else if ((r_stop_newline && (i_text_byte == NEWLINE_BYTE))
                                 || i_last_byte) begin
                        push = 1'b1;
                    end
                end
                if (push) begin
                    n_answered = 1'b1;
                    if (i_last_byte) begin
                        n_answered   = 1'b0;
                        n_bytes_read = '0;
                    end
                end
            end
        end
        new_res.pos = raw_pos & POS_MASK;
    end

    // Two-entry result queue: head drives the ports, skid catches a stalled push
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out_res    = r_out_res;
        n_skid_res   = r_skid_res;
        if (r_skid_valid) begin
            if (pop) begin
                n_out_res    = r_skid_res;
                n_skid_valid = 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid || pop) begin
                n_out_res   = new_res;
                n_out_valid = 1'b1;
            end else begin
                n_skid_res   = new_res;
                n_skid_valid = 1'b1;
            end
        end else if (pop) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_read <= '0;
            r_answered   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_bytes_read <= n_bytes_read;
            r_answered   <= n_answered;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_window   <= n_window;
        r_out_res  <= n_out_res;
        r_skid_res <= n_skid_res;
    end

    assign o_out_valid      = r_out_valid;
    assign o_found          = r_out_res.found;
    assign o_match_position = r_out_res.pos;

endmodule

/* rtl/ssf_checker.sv */
// ============================================================================
// Substring scan finder port checker
// Port-level checks on the result queue of the substring scan finder.
// ============================================================================
`include "substring_scan_finder_top_macros.svh"

module ssf_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               o_in_ready,
    input  logic                               o_out_valid,
    input  logic                               i_out_ready,
    input  logic                               o_found,
    input  logic [ssf_pkg::POS_BITS-1:0]       o_match_position
);

    // A stalled result stays offered
    `SSF_ASSERT_NEXT(a_out_held, o_out_valid && !i_out_ready, o_out_valid,
                     "result dropped while stalled")

    // A stalled result keeps its payload
    `SSF_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready,
                     $stable(o_found) && $stable(o_match_position),
                     "result payload changed while stalled")

    // Input side stalls only once a result has backed up behind a held one
    `SSF_ASSERT_SAME(a_ready_fall, $fell(o_in_ready), $past(o_out_valid && !i_out_ready),
                     "input stalled without a held result")

    // A fresh result needs a byte request taken the cycle before
    `SSF_ASSERT_SAME(a_out_cause, $rose(o_out_valid), $past(i_in_valid && o_in_ready),
                     "result appeared without a byte request")

endmodule

bind substring_scan_finder_top ssf_checker u_ssf_checker (.*);

/* bench/substring_scan_finder_top_test.sv */
`timescale 1ns / 1ps
// ============================================================================
// Substring scan finder regression bench
// Streams text searches through the scan finder under a range of pattern,
// direction, line-mode and start settings, predicts every hit or miss in a
// scoreboard mirror of the block, and checks each result in order while both
// request channels idle and stall at random.
// ============================================================================
module substring_scan_finder_top_test;
    import ssf_pkg::*;

    localparam int RANDOM_BYTES   = 1900;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 4000;

    // ------------------------------------------------------------------------
    // Scoreboard: mirror of the search state and queue of expected results
    // ------------------------------------------------------------------------
    class scan_scoreboard;
        t_len        pat_len;
        logic [63:0] pat_lo;
        logic [63:0] pat_hi;
        logic        backward;
        logic        line_mode;
        t_pos        start_pos;
        logic [7:0]  window [PATTERN_STORE];
        t_count      nread;
        logic        answered;
        t_result     expected_hits [$];
        int          errors;
        int          live_bytes;

        function new();
            pat_len    = '0;
            pat_lo     = '0;
            pat_hi     = '0;
            backward   = 1'b0;
            line_mode  = 1'b0;
            start_pos  = '0;
            errors     = 0;
            live_bytes = 0;
            clear_search();
        endfunction

        function void clear_search();
            foreach (window[i]) window[i] = 8'h00;
            nread    = '0;
            answered = 1'b0;
        endfunction

        function int eff_length();
            return (pat_len > PATTERN_STORE) ? PATTERN_STORE : int'(pat_len);
        endfunction

        function logic [7:0] pattern_byte(int i);
            return (i < 8) ? pat_lo[i*8 +: 8] : pat_hi[(i-8)*8 +: 8];
        endfunction

        function void write_reg(t_cfg_index idx, logic [63:0] data);
            case (idx)
                CFG_PATTERN_LENGTH: pat_len   = data[LEN_BITS-1:0];
                CFG_PATTERN_LOW:    pat_lo    = data;
                CFG_PATTERN_HIGH:   pat_hi    = data;
                CFG_SEARCH_BACK:    backward  = data[0];
                CFG_STOP_NEWLINE:   line_mode = data[0];
                CFG_START_POSITION: start_pos = data[POS_BITS-1:0];
                default: ;
            endcase
        endfunction

        // Accepted text byte: advance the window and queue any result it causes
        function void note_text_byte(logic [7:0] b, logic last);
            int         eff;
            logic       hit;
            logic       give;
            logic [7:0] w;
            t_result    r;
            eff = eff_length();
            live_bytes++;
            // after a result, bytes are dropped until the end of the text
            if (answered) begin
                if (last) clear_search();
                return;
            end
            r.found = 1'b0;
            r.pos   = start_pos;
            give    = 1'b0;
            if (eff == 0 && nread == '0) begin
                // empty pattern hits at the start on the first byte
                r.found = 1'b1;
                give    = 1'b1;
            end else begin
                for (int i = PATTERN_STORE - 1; i > 0; i--) window[i] = window[i-1];
                window[0] = b;
                if (nread != '1) nread++;
                hit = (eff != 0) && (nread >= t_count'(eff));
                for (int i = 0; i < eff; i++) begin
                    w = backward ? window[i] : window[eff-1-i];
                    if (w != pattern_byte(i)) hit = 1'b0;
                end
                if (hit) begin
                    r.found = 1'b1;
                    r.pos   = backward ? t_pos'(start_pos - nread)
                                       : t_pos'(start_pos + nread - t_pos'(eff));
                end
                give = hit || (line_mode && b == NEWLINE_BYTE) || last;
            end
            if (give) begin
                expected_hits.push_back(r);
                answered = 1'b1;
                if (last) clear_search();
            end
        endfunction

        // Accepted result: compare with the oldest expectation
        function void check_result(logic found, t_pos pos);
            t_result e;
            if (expected_hits.size() == 0) begin
                $error("unexpected result: found %0d match_position %h", found, pos);
                errors++;
                return;
            end
            e = expected_hits.pop_front();
            if (found !== e.found) begin
                $error("found: expected %0d, actual %0d", e.found, found);
                errors++;
            end
            if (pos !== e.pos) begin
                $error("match_position: expected %h, actual %h", e.pos, pos);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_in_valid       = 1'b0;
    logic                  o_in_ready;
    logic [7:0]            i_text_byte      = 8'h00;
    logic                  i_last_byte      = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready      = 1'b0;
    logic                  o_found;
    logic [POS_BITS-1:0]   o_match_position;
    logic                  i_cfg_valid      = 1'b0;
    logic                  o_cfg_ready;
    logic [INDEX_BITS-1:0] i_cfg_index      = '0;
    logic [DATA_BITS-1:0]  i_cfg_data       = '0;

    scan_scoreboard board;
    int send_idle_pct = 30;
    int recv_idle_pct = 78;
    int hold_requests = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    substring_scan_finder_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_text_byte      (i_text_byte),
        .i_last_byte      (i_last_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_found          (o_found),
        .o_match_position (o_match_position),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Monitor: every accepted request goes to the scoreboard
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                board.write_reg(t_cfg_index'(i_cfg_index), i_cfg_data);
            if (i_in_valid && o_in_ready)
                board.note_text_byte(i_text_byte, i_last_byte);
            if (o_out_valid && i_out_ready)
                board.check_result(o_found, o_match_position);
        end
    end

    // Watchdog on cycles with no request moving on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("substring_scan_finder_top regression: fail");
            $finish;
        end
    end

    // Result receiver: random stalls, plus long hold-offs on request
    always @(negedge i_clk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers (called at the falling edge, return at the falling edge)
    // ------------------------------------------------------------------------
    task automatic offer_text(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_text_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg_port(input t_cfg_index idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stop offering and wait for every expected result, then let the block settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (board.expected_hits.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Text byte for a search: mostly pattern bytes and newlines when narrow
    function automatic logic [7:0] pick_text_byte(input bit narrow);
        int r;
        int eff;
        eff = board.eff_length();
        r   = $urandom_range(0, 7);
        if (!narrow || r == 1) return 8'($urandom_range(0, 255));
        if (r == 0) return NEWLINE_BYTE;
        if (eff == 0) return 8'h61 + 8'($urandom_range(0, 1));
        return board.pattern_byte($urandom_range(0, eff - 1));
    endfunction

    // One search: filler, an optional (maybe cut short) copy of the pattern,
    // more filler, last byte marked
    task automatic send_search(input bit short_one);
        int         eff;
        int         pre;
        int         post;
        int         planted;
        int         total;
        int         j;
        bit         narrow;
        logic [7:0] b;
        eff     = board.eff_length();
        narrow  = ($urandom_range(0, 4) != 0);
        planted = 0;
        if ($urandom_range(0, 9) < 6)
            planted = ($urandom_range(0, 4) == 0 && eff > 0) ? eff - 1 : eff;
        if (short_one) begin
            pre  = $urandom_range(0, 2);
            post = 0;
        end else begin
            pre  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 45)
                                               : $urandom_range(0, 16);
            post = $urandom_range(0, 6);
        end
        total = pre + planted + post;
        if (total == 0) total = 1;
        for (int k = 0; k < total; k++) begin
            j = k - pre;
            if (j >= 0 && j < planted)
                b = board.backward ? board.pattern_byte(eff - 1 - j) : board.pattern_byte(j);
            else
                b = pick_text_byte(narrow);
            offer_text(b, k == total - 1);
        end
    endtask

    task automatic b_put(inout logic [63:0] lo, inout logic [63:0] hi,
                         input int k, input logic [7:0] v);
        if (k < 8)
            lo[k*8 +: 8] = v;
        else
            hi[(k-8)*8 +: 8] = v;
    endtask

    // Pick and write a full setting; low selectors give the extremes
    task automatic apply_setting(input int sel);
        logic [4:0]  len;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [31:0] start;
        logic        back;
        logic        line;
        case (sel)
            0:       len = 5'd16;
            1:       len = 5'd31;
            2:       len = 5'd0;
            3:       len = 5'd1;
            4:       len = 5'($urandom_range(17, 30));
            5:       len = 5'($urandom_range(9, 16));
            default: len = 5'($urandom_range(2, 8));
        endcase
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        if (sel == 0) begin
            lo = '1;
            hi = '1;
        end else if (sel == 1) begin
            lo = '0;
            hi = '0;
        end else if ($urandom_range(0, 3) != 0) begin
            // narrow pattern alphabet, newlines included
            for (int k = 0; k < 16; k++) begin
                case ($urandom_range(0, 3))
                    0:       b_put(lo, hi, k, 8'h61);
                    1:       b_put(lo, hi, k, 8'h62);
                    2:       b_put(lo, hi, k, NEWLINE_BYTE);
                    default: ;
                endcase
            end
        end
        case (sel)
            0:       start = '1;
            1:       start = '0;
            2:       start = 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
            3:       start = 32'($urandom_range(0, 16));
            default: start = $urandom;
        endcase
        back = (sel < 2) ? sel[0] : 1'($urandom_range(0, 1));
        line = (sel == 1) ? 1'b1 : ($urandom_range(0, 2) == 0);
        write_reg_port(CFG_PATTERN_LENGTH, 64'(len));
        write_reg_port(CFG_PATTERN_LOW, lo);
        write_reg_port(CFG_PATTERN_HIGH, hi);
        write_reg_port(CFG_SEARCH_BACK, 64'(back));
        write_reg_port(CFG_STOP_NEWLINE, 64'(line));
        write_reg_port(CFG_START_POSITION, 64'(start));
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Directed searches: empty pattern, wrap in both directions, line mode
    // ------------------------------------------------------------------------
    task automatic run_directed();
        // empty pattern after reset hits at once; the rest of the text is dropped
        offer_text(8'h00, 1'b0);
        offer_text(8'hFF, 1'b1);
        drain_results();

        // forward hit whose position wraps past all ones
        write_reg_port(CFG_PATTERN_LENGTH, 64'd3);
        write_reg_port(CFG_PATTERN_LOW, 64'h0000_0000_0063_6261);
        write_reg_port(CFG_PATTERN_HIGH, '1);
        write_reg_port(CFG_START_POSITION, 64'hFFFF_FFFF);
        i_cfg_valid <= 1'b0;
        offer_text(8'h78, 1'b0);
        offer_text(8'h61, 1'b0);
        offer_text(8'h62, 1'b0);
        offer_text(8'h63, 1'b0);
        offer_text(8'h7A, 1'b1);
        drain_results();

        // backward hit on the last byte, position wraps below zero
        write_reg_port(CFG_SEARCH_BACK, 64'd1);
        write_reg_port(CFG_PATTERN_LENGTH, 64'd2);
        write_reg_port(CFG_PATTERN_LOW, 64'h0000_0000_0000_6261);
        write_reg_port(CFG_START_POSITION, 64'd1);
        i_cfg_valid <= 1'b0;
        offer_text(8'h71, 1'b0);
        offer_text(8'h62, 1'b0);
        offer_text(8'h61, 1'b1);
        drain_results();

        // line mode: newline ends the search, then a lone last byte misses
        write_reg_port(CFG_SEARCH_BACK, 64'd0);
        write_reg_port(CFG_STOP_NEWLINE, 64'd1);
        write_reg_port(CFG_START_POSITION, 64'd7);
        i_cfg_valid <= 1'b0;
        offer_text(8'h61, 1'b0);
        offer_text(NEWLINE_BYTE, 1'b0);
        offer_text(8'h62, 1'b1);
        offer_text(8'h61, 1'b1);
        drain_results();

        // a match ending on a newline wins over the line stop
        write_reg_port(CFG_PATTERN_LOW, 64'h0000_0000_0000_0A61);
        i_cfg_valid <= 1'b0;
        offer_text(8'h61, 1'b0);
        offer_text(NEWLINE_BYTE, 1'b1);
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int  base;
        int  stage;
        int  new_stage;
        int  phase_no;
        int  sel;
        bit  burst;
        board = new();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();

        base     = board.live_bytes;
        stage    = 0;
        phase_no = 0;
        while (board.live_bytes - base < RANDOM_BYTES) begin
            drain_results();
            new_stage = ((board.live_bytes - base) * 3) / RANDOM_BYTES;
            burst     = (new_stage != stage) || (phase_no == 3);
            if (new_stage != stage) begin
                stage = new_stage;
                case (stage)
                    1: begin
                        send_idle_pct = 78;
                        recv_idle_pct = 30;
                    end
                    default: begin
                        send_idle_pct = 0;
                        recv_idle_pct = 0;
                    end
                endcase
            end
            sel = (phase_no < 6) ? phase_no : $urandom_range(2, 12);
            apply_setting(sel);
            if (burst) begin
                // receiver holds off while short searches pile up behind it
                hold_requests++;
                repeat (12) send_search(1'b1);
            end else begin
                repeat ($urandom_range(2, 8)) send_search(1'b0);
            end
            phase_no++;
        end
        drain_results();

        if (board.errors == 0 && board.expected_hits.size() == 0)
            $display("substring_scan_finder_top regression: pass");
        else
            $display("substring_scan_finder_top regression: fail");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/ssf_pkg.sv
rtl/ssf_window_match.sv
rtl/substring_scan_finder_top.sv
rtl/ssf_checker.sv
bench/substring_scan_finder_top_test.sv
